### hw/rtl/weighted_median_location_macros.svh
// assertion macros shared by the weighted median location block
`ifndef WEIGHTED_MEDIAN_LOCATION_MACROS_SVH
`define WEIGHTED_MEDIAN_LOCATION_MACROS_SVH

// check that holds outside reset
`define WML_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check that also covers the reset cycles
`define WML_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/wml_pkg.sv
// types, constants and widths shared by the weighted median location block
`timescale 1ns / 1ps

package wml_pkg;

   localparam int NUM_POSITIONS = 32768;
   localparam int ADDR_W        = $clog2(NUM_POSITIONS);

   localparam int POS_W    = 15;
   localparam int WEIGHT_W = 16;
   localparam int BIN_W    = 32;
   localparam int TOTAL_W  = 48;
   localparam int COST_W   = 63;
   localparam int MAG_W    = TOTAL_W + 1;
   localparam int PROD_W   = WEIGHT_W + ADDR_W;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [BIN_W-1:0]   BIN_MAX   = {BIN_W{1'b1}};
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
   localparam logic [COST_W-1:0]  COST_MAX  = {COST_W{1'b1}};

   localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(NUM_POSITIONS - 1);
   localparam logic [ADDR_W-1:0] PENULT_ADDR = ADDR_W'(NUM_POSITIONS - 2);

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   typedef struct packed {
      logic                cmd;
      logic [POS_W-1:0]    position;
      logic [WEIGHT_W-1:0] weight;
   } wml_req_type;

   typedef struct packed {
      logic [POS_W-1:0]  best_position;
      logic [COST_W-1:0] min_cost;
      logic              saturated;
   } wml_rsp_type;

   // classified item handed from the front part to the back part
   typedef struct packed {
      logic                finish;
      logic [ADDR_W-1:0]   addr;
      logic [WEIGHT_W-1:0] weight;
   } wml_item_type;

   typedef struct packed {
      logic clearing;
      logic walking;
   } wml_stat_type;

endpackage

### hw/rtl/wml_ram.sv
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module wml_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/wml_front.sv
// front part: accepts request beats, drops out-of-range loads, queues the rest
`timescale 1ns / 1ps

module wml_front import wml_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  wml_req_type  req_data,
   output logic         req_full,
   input  logic         hold,
   output logic         q_valid,
   output wml_item_type q_item,
   input  logic         q_pop
);

   wml_item_type        q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   wml_item_type        item_in;
   logic                accept;
   logic                in_range;
   logic                enq;
   logic                deq;

   assign req_full = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH)) || hold;
   assign accept   = req_push && !req_full;
   assign in_range = 32'(req_data.position) < 32'(NUM_POSITIONS);
   assign enq      = accept && ((req_data.cmd == CMD_FINISH) || in_range);
   assign q_valid  = (count_ff != '0);
   assign deq      = q_pop && q_valid;
   assign q_item   = q_ff[rd_ptr_ff];

   always_comb begin
      item_in.finish = (req_data.cmd == CMD_FINISH);
      item_in.addr   = ADDR_W'(req_data.position);
      item_in.weight = req_data.weight;
      wr_ptr_in      = enq ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in      = deq ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in       = count_ff;
      if (enq && !deq) begin
         count_in = count_ff + (QPTR_W + 1)'(1);
      end else if (deq && !enq) begin
         count_in = count_ff - (QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[wr_ptr_ff] <= item_in;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### hw/rtl/wml_back.sv
// back part: histogram updates, the position walk and the result register
`timescale 1ns / 1ps

module wml_back import wml_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   input  wml_item_type q_item,
   output logic         q_pop,
   output logic         rsp_valid,
   output wml_rsp_type  rsp_data,
   input  logic         rsp_pop,
   output wml_stat_type stat
);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_WALK,
      ST_DRAIN
   } state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [ADDR_W-1:0]   ld_addr_ff, ld_addr_in;
   logic [WEIGHT_W-1:0] ld_weight_ff, ld_weight_in;
   logic [PROD_W-1:0]   ld_prod_ff, ld_prod_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [COST_W-1:0]   origin_ff, origin_in;
   logic                flag_ff, flag_in;

   logic                s0_valid_ff, s0_valid_in;
   logic [ADDR_W-1:0]   s0_addr_ff, s0_addr_in;
   logic [TOTAL_W-1:0]  left_ff, left_in;
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_last_ff, s1_last_in;
   logic [ADDR_W-1:0]   s1_pos_ff, s1_pos_in;
   logic                s2_valid_ff, s2_valid_in;
   logic                s2_last_ff, s2_last_in;
   logic [ADDR_W-1:0]   s2_pos_ff, s2_pos_in;
   logic                s2_up_ff, s2_up_in;
   logic [MAG_W-1:0]    s2_mag_ff, s2_mag_in;
   logic [COST_W-1:0]   cost_ff, cost_in;
   logic                s3_valid_ff, s3_valid_in;
   logic                s3_last_ff, s3_last_in;
   logic [ADDR_W-1:0]   s3_pos_ff, s3_pos_in;
   logic [COST_W-1:0]   best_cost_ff, best_cost_in;
   logic [ADDR_W-1:0]   best_pos_ff, best_pos_in;
   logic                rsp_valid_ff, rsp_valid_in;
   wml_rsp_type         rsp_ff, rsp_in;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   logic [BIN_W-1:0]    ram_wdata;
   logic                ram_re;
   logic [ADDR_W-1:0]   ram_raddr;
   logic [BIN_W-1:0]    ram_rdata;

   logic [BIN_W:0]      bin_sum;
   logic [TOTAL_W:0]    total_sum;
   logic [COST_W:0]     origin_sum;
   logic [TOTAL_W:0]    left_sum;
   logic [MAG_W-1:0]    twice;
   logic [MAG_W-1:0]    total_ext;
   logic [COST_W:0]     cost_sum;
   logic [COST_W-1:0]   mag_ext;

   wml_ram #(
      .WIDTH (BIN_W),
      .DEPTH (NUM_POSITIONS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      ld_addr_in   = ld_addr_ff;
      ld_weight_in = ld_weight_ff;
      ld_prod_in   = ld_prod_ff;
      total_in     = total_ff;
      origin_in    = origin_ff;
      flag_in      = flag_ff;
      left_in      = left_ff;
      cost_in      = cost_ff;
      best_cost_in = best_cost_ff;
      best_pos_in  = best_pos_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff;
      ram_wdata    = '0;
      ram_re       = 1'b0;
      ram_raddr    = addr_ff;

      bin_sum    = {1'b0, ram_rdata} + (BIN_W + 1)'(ld_weight_ff);
      total_sum  = {1'b0, total_ff} + (TOTAL_W + 1)'(ld_weight_ff);
      origin_sum = {1'b0, origin_ff} + (COST_W + 1)'(ld_prod_ff);
      left_sum   = {1'b0, left_ff} + (TOTAL_W + 1)'(ram_rdata);
      twice      = {left_ff, 1'b0};
      total_ext  = {1'b0, total_ff};
      mag_ext    = COST_W'(s2_mag_ff);
      cost_sum   = {1'b0, cost_ff} + {1'b0, mag_ext};

      if (rsp_pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = addr_ff;
            addr_in   = addr_ff + ADDR_W'(1);
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               if (!q_item.finish) begin
                  q_pop        = 1'b1;
                  ram_re       = 1'b1;
                  ram_raddr    = q_item.addr;
                  ld_addr_in   = q_item.addr;
                  ld_weight_in = q_item.weight;
                  ld_prod_in   = PROD_W'(q_item.weight) * PROD_W'(q_item.addr);
                  state_in     = ST_LOAD;
               end else if (!rsp_valid_ff) begin
                  q_pop        = 1'b1;
                  addr_in      = '0;
                  left_in      = '0;
                  cost_in      = origin_ff;
                  best_cost_in = origin_ff;
                  best_pos_in  = '0;
                  state_in     = ST_WALK;
               end
            end
         end
         ST_LOAD: begin
            // read-modify-write of one bin plus the two running sums
            ram_we    = 1'b1;
            ram_waddr = ld_addr_ff;
            if (bin_sum > {1'b0, BIN_MAX}) begin
               ram_wdata = BIN_MAX;
               flag_in   = 1'b1;
            end else begin
               ram_wdata = bin_sum[BIN_W-1:0];
            end
            if (total_sum > {1'b0, TOTAL_MAX}) begin
               total_in = TOTAL_MAX;
               flag_in  = 1'b1;
            end else begin
               total_in = total_sum[TOTAL_W-1:0];
            end
            if (origin_sum > {1'b0, COST_MAX}) begin
               origin_in = COST_MAX;
               flag_in   = 1'b1;
            end else begin
               origin_in = origin_sum[COST_W-1:0];
            end
            state_in = ST_IDLE;
         end
         ST_WALK: begin
            ram_re    = 1'b1;
            ram_raddr = addr_ff;
            addr_in   = addr_ff + ADDR_W'(1);
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // stage 0: bin data back from the ram, cleared behind the read
      s0_valid_in = (state_ff == ST_WALK);
      s0_addr_in  = addr_ff;
      s1_valid_in = 1'b0;
      s1_last_in  = (s0_addr_ff == PENULT_ADDR);
      s1_pos_in   = s0_addr_ff + ADDR_W'(1);
      if (s0_valid_ff) begin
         ram_we    = 1'b1;
         ram_waddr = s0_addr_ff;
         ram_wdata = '0;
         // the last bin only needs clearing, it moves no cost
         if (s0_addr_ff != LAST_ADDR) begin
            s1_valid_in = 1'b1;
            if (left_sum > {1'b0, TOTAL_MAX}) begin
               left_in = TOTAL_MAX;
               flag_in = 1'b1;
            end else begin
               left_in = left_sum[TOTAL_W-1:0];
            end
         end
      end

      // stage 1: signed step 2*left - total as direction and magnitude
      s2_valid_in = s1_valid_ff;
      s2_last_in  = s1_last_ff;
      s2_pos_in   = s1_pos_ff;
      s2_up_in    = (twice >= total_ext);
      s2_mag_in   = s2_up_in ? twice - total_ext : total_ext - twice;

      // stage 2: running cost, clamped at both ends
      s3_valid_in = s2_valid_ff;
      s3_last_in  = s2_last_ff;
      s3_pos_in   = s2_pos_ff;
      if (s2_valid_ff) begin
         if (s2_up_ff) begin
            if (cost_sum > {1'b0, COST_MAX}) begin
               cost_in = COST_MAX;
               flag_in = 1'b1;
            end else begin
               cost_in = cost_sum[COST_W-1:0];
            end
         end else if (mag_ext > cost_ff) begin
            cost_in = '0;
            flag_in = 1'b1;
         end else begin
            cost_in = cost_ff - mag_ext;
         end
      end

      // stage 3: keep the lowest position with the smallest cost
      if (s3_valid_ff) begin
         if (cost_ff < best_cost_ff) begin
            best_cost_in = cost_ff;
            best_pos_in  = s3_pos_ff;
         end
         if (s3_last_ff) begin
            rsp_in.best_position = POS_W'(best_pos_in);
            rsp_in.min_cost      = best_cost_in;
            rsp_in.saturated     = flag_ff;
            rsp_valid_in         = 1'b1;
            total_in             = '0;
            origin_in            = '0;
            flag_in              = 1'b0;
            left_in              = '0;
            state_in             = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      ld_addr_ff   <= ld_addr_in;
      ld_weight_ff <= ld_weight_in;
      ld_prod_ff   <= ld_prod_in;
      s0_addr_ff   <= s0_addr_in;
      s1_last_ff   <= s1_last_in;
      s1_pos_ff    <= s1_pos_in;
      s2_last_ff   <= s2_last_in;
      s2_pos_ff    <= s2_pos_in;
      s2_up_ff     <= s2_up_in;
      s2_mag_ff    <= s2_mag_in;
      s3_last_ff   <= s3_last_in;
      s3_pos_ff    <= s3_pos_in;
      cost_ff      <= cost_in;
      best_cost_ff <= best_cost_in;
      best_pos_ff  <= best_pos_in;
      rsp_ff       <= rsp_in;
      if (reset) begin
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         total_ff     <= '0;
         origin_ff    <= '0;
         flag_ff      <= 1'b0;
         left_ff      <= '0;
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         total_ff     <= total_in;
         origin_ff    <= origin_in;
         flag_ff      <= flag_in;
         left_ff      <= left_in;
         s0_valid_ff  <= s0_valid_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data      = rsp_ff;
   assign stat.clearing = (state_ff == ST_CLEAR);
   assign stat.walking  = (state_ff == ST_WALK) || (state_ff == ST_DRAIN);

endmodule

### hw/rtl/weighted_median_location.sv
// Weighted median location: load beats (cmd 0) add a weight to the histogram bin at their
// position and to the running total and origin cost; a finish beat (cmd 1) walks every
// position in ascending order and returns the lowest position of minimal weighted absolute
// distance, that cost and a saturation flag, then clears the set. A four-beat front queue
// takes one request beat per cycle while it has room. The back part reads the bin of a load
// in the idle state and writes it back in the load state, using the separate read and write
// ports of the histogram memory, and takes the next beat only after that write. A finish
// beat occupies the back part for the dequeue, one memory read per position and the drain of
// the cost pipeline, and starts only when the result register is free; the walk clears each
// bin behind its read. After reset a clearing pass zeroes the histogram with req_full high.
`timescale 1ns / 1ps
`include "weighted_median_location_macros.svh"

module weighted_median_location import wml_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  wml_req_type req_data,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output wml_rsp_type rsp_data
);

   logic         q_valid;
   wml_item_type q_item;
   logic         q_pop;
   logic         rsp_valid;
   wml_stat_type stat;

   wml_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .hold     (stat.clearing),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   wml_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop),
      .stat      (stat)
   );

   assign rsp_empty = !rsp_valid;

   `WML_ASSERT_ALWAYS(a_reset_starts_clear, clock, reset |=> req_full, "no clear after reset")
   `WML_ASSERT(a_clear_blocks_req, clock, reset, stat.clearing |-> req_full, "beat during clear")
   `WML_ASSERT(a_walk_slot_free, clock, reset, stat.walking |-> rsp_empty, "walk with result")
   `WML_ASSERT(a_pop_empties, clock, reset, (!rsp_empty && rsp_pop) |=> rsp_empty, "extra result")

endmodule
